/* src/tms_pkg.sv */
// ----------------------------------------------------------------------------
// Touch median sampler package
// Shared defaults and the link type between neighboring sort cells.
// ----------------------------------------------------------------------------
package tms_pkg;

	// Default number of samples in one axis group.
	localparam int WINDOW_LEN_DEF = 7;
	// Default converter sample width.
	localparam int SAMPLE_BITS_DEF = 12;

	// Status that one sort cell hands to its right-hand neighbor.
	typedef struct packed {
		logic gt;   // cell is empty or its value exceeds the new sample
	} tms_link_t;

endpackage : tms_pkg

/* src/tms_if.sv */
// ----------------------------------------------------------------------------
// Touch median sampler channels
// Valid/ready channels for converter samples and for filtered positions.
// ----------------------------------------------------------------------------
interface tms_adc_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic                   pressed;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output pressed, output sample, input ready);
	modport sink   (input valid, input pressed, input sample, output ready);
endinterface : tms_adc_if

interface tms_pos_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] pos_x;
	logic [SAMPLE_BITS-1:0] pos_y;
	logic                   touched;

	modport source (output valid, output pos_x, output pos_y, output touched, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input touched, output ready);
endinterface : tms_pos_if

/* src/touch_median_sampler.sv */
// ----------------------------------------------------------------------------
// Touch median sampler
// Qualifies touch-panel readings: median of each axis group of samples,
// held X/Y position, reported touched after a full reading or untouched
// whenever the panel is released.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output register is empty or being
// taken; each sample is sorted into a chain of WINDOW_LEN cells in the cycle
// it is accepted, and the median is taken from the chain's next-state at the
// middle cell. A result is registered when the item that ends it is accepted.
// Reset: phase returns to the discard-X step, held positions clear to zero,
// the output register empties; sample cells are not reset.
module touch_median_sampler
	import tms_pkg::*;
#(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	tms_adc_if.sink   adc,
	tms_pos_if.source pos
);

	localparam int GROUP_LEN = WINDOW_LEN + 1;
	localparam int SEQ_LEN   = 2 * GROUP_LEN;
	localparam int PH_W      = $clog2(SEQ_LEN);
	localparam int MID       = WINDOW_LEN / 2;

	logic [PH_W-1:0]        phase_q;
	logic [SAMPLE_BITS-1:0] held_x_q;
	logic [SAMPLE_BITS-1:0] held_y_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] pos_x_q;
	logic [SAMPLE_BITS-1:0] pos_y_q;
	logic                   touched_q;

	logic                   acc;
	logic                   ins;
	logic                   last_x;
	logic                   last_y;
	logic [PH_W-1:0]        fill;
	logic [SAMPLE_BITS-1:0] median;

	tms_link_t              link [WINDOW_LEN];
	logic [SAMPLE_BITS-1:0] val  [WINDOW_LEN];
	logic [SAMPLE_BITS-1:0] nxt  [WINDOW_LEN];

	// The output register frees up when its item is taken.
	assign adc.ready = !out_valid_q || pos.ready;
	assign acc       = adc.valid && adc.ready;

	// Sequence decode: discard steps write nothing.
	assign last_x = (phase_q == PH_W'(GROUP_LEN - 1));
	assign last_y = (phase_q == PH_W'(SEQ_LEN - 1));
	assign ins    = acc && adc.pressed && (phase_q != '0) && (phase_q != PH_W'(GROUP_LEN));

	// Samples already in the chain for the current group.
	always_comb begin
		if (phase_q < PH_W'(GROUP_LEN)) begin
			fill = phase_q - PH_W'(1);
		end else begin
			fill = phase_q - PH_W'(GROUP_LEN + 1);
		end
	end

	// Insertion chain of sort cells, smallest value on the left.
	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		tms_link_t              left_link;
		logic [SAMPLE_BITS-1:0] left_val;

		if (i == 0) begin : g_head
			assign left_link = '0;
			assign left_val  = '0;
		end else begin : g_body
			assign left_link = link[i-1];
			assign left_val  = val[i-1];
		end

		tms_cell #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.ins       (ins),
			.occ       (PH_W'(i) < fill),
			.sample    (adc.sample),
			.left_link (left_link),
			.left_val  (left_val),
			.link      (link[i]),
			.val       (val[i]),
			.nxt       (nxt[i])
		);
	end

	// Median of the group once its last sample is sorted in.
	assign median = nxt[MID];

	// Sequence position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (acc) begin
			if (!adc.pressed || last_y) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + PH_W'(1);
			end
		end
	end

	// Held positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (ins) begin
			if (last_x) begin
				held_x_q <= median;
			end
			if (last_y) begin
				held_y_q <= median;
			end
		end
	end

	// Output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && (!adc.pressed || last_y)) begin
			out_valid_q <= 1'b1;
		end else if (pos.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (acc && !adc.pressed) begin
			pos_x_q   <= held_x_q;
			pos_y_q   <= held_y_q;
			touched_q <= 1'b0;
		end else if (acc && last_y) begin
			pos_x_q   <= held_x_q;
			pos_y_q   <= median;
			touched_q <= 1'b1;
		end
	end

	assign pos.valid   = out_valid_q;
	assign pos.pos_x   = pos_x_q;
	assign pos.pos_y   = pos_y_q;
	assign pos.touched = touched_q;

	// A completed reading leaves a touched result and restarts the sequence.
	a_touched_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && adc.pressed && last_y |=> out_valid_q && touched_q && (phase_q == '0))
		else $error("completed reading did not produce a touched result");

	// A release leaves an untouched result and restarts the sequence.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !adc.pressed |=> out_valid_q && !touched_q && (phase_q == '0))
		else $error("release did not produce an untouched result");

	// Mid-sequence samples produce no result and advance the phase.
	a_mid_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && adc.pressed && !last_y && !out_valid_q |=>
		!out_valid_q && (phase_q == $past(phase_q) + PH_W'(1)))
		else $error("mid-sequence sample produced a result or lost its step");

	// A new X median only lands at the end of the X group.
	a_held_x: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && adc.pressed && last_x) |=> $stable(held_x_q))
		else $error("held X position changed outside the end of the X group");

endmodule : touch_median_sampler

/* src/tms_cell.sv */
// ----------------------------------------------------------------------------
// Touch median sampler sort cell
// One slot of the insertion chain: keeps its value, shifts in its left
// neighbor's value, or takes the new sample, so the chain stays sorted.
// ----------------------------------------------------------------------------
module tms_cell
	import tms_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   ins,
	input  logic                   occ,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  tms_link_t              left_link,
	input  logic [SAMPLE_BITS-1:0] left_val,
	output tms_link_t              link,
	output logic [SAMPLE_BITS-1:0] val,
	output logic [SAMPLE_BITS-1:0] nxt
);

	logic [SAMPLE_BITS-1:0] val_q;

	// An empty cell counts as larger than any sample.
	always_comb begin
		link.gt = !occ || (val_q > sample);
	end

	// Keep a value no larger than the sample, else take the neighbor's value if it moves right,
	// else the new sample lands here.
	always_comb begin
		if (!link.gt) begin
			nxt = val_q;
		end else if (left_link.gt) begin
			nxt = left_val;
		end else begin
			nxt = sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule : tms_cell

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch median sampler testbench
// Drives pressed flags and converter samples into the block, predicts the
// filtered positions with its own copy of the axis groups and held values,
// and checks every position item in order under varying idle patterns.
// ----------------------------------------------------------------------------
module tb_top
	import tms_pkg::*;
();

	localparam int WIN         = WINDOW_LEN_DEF;
	localparam int SBITS       = SAMPLE_BITS_DEF;
	localparam int GRP         = WIN + 1;
	localparam int SEQ         = 2 * GRP;
	localparam int MAXS        = (1 << SBITS) - 1;
	localparam int ITEMS_PHASE = 520;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 200000;
	localparam int DRAIN       = 20;

	typedef logic [SBITS-1:0] sample_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		logic    touched;
	} position_t;

	// Predicts positions from accepted items and checks the block's output.
	class position_board;
		sample_t     cells [WIN];
		int unsigned step;
		sample_t     held_x;
		sample_t     held_y;
		position_t   expected_q [$];
		int unsigned mismatches;

		function new();
			step = 0;
			held_x = '0;
			held_y = '0;
			mismatches = 0;
			foreach (cells[i]) cells[i] = '0;
		endfunction

		// Middle value of the current group after a plain exchange sort.
		function sample_t group_median();
			sample_t v [WIN];
			sample_t t;
			v = cells;
			for (int i = 0; i < WIN - 1; i++) begin
				for (int j = 0; j < WIN - 1 - i; j++) begin
					if (v[j] > v[j+1]) begin
						t = v[j];
						v[j] = v[j+1];
						v[j+1] = t;
					end
				end
			end
			return v[WIN/2];
		endfunction

		task report(input string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Advances the predicted sequence by one accepted item.
		function void note_item(input logic pressed, input sample_t s);
			position_t r;
			if (!pressed) begin
				step = 0;
				r.x = held_x;
				r.y = held_y;
				r.touched = 1'b0;
				expected_q.push_back(r);
				return;
			end
			if (step >= SEQ) step = 0;
			// Discard steps leave the group alone.
			if (step != 0 && step != GRP) begin
				if (step < GRP) cells[step-1] = s;
				else cells[step-GRP-1] = s;
			end
			if (step == GRP - 1) begin
				held_x = group_median();
			end else if (step == SEQ - 1) begin
				held_y = group_median();
				step = 0;
				r.x = held_x;
				r.y = held_y;
				r.touched = 1'b1;
				expected_q.push_back(r);
				return;
			end
			step++;
		endfunction

		task check_result(input sample_t x, input sample_t y, input logic touched);
			position_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected position x=%0d y=%0d touched=%0b",
					x, y, touched));
				return;
			end
			e = expected_q.pop_front();
			if (x !== e.x)
				report($sformatf("pos_x got %0d want %0d", x, e.x));
			if (y !== e.y)
				report($sformatf("pos_y got %0d want %0d", y, e.y));
			if (touched !== e.touched)
				report($sformatf("touched got %0b want %0b", touched, e.touched));
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_idle_pct = 17;
	int unsigned recv_idle_pct = 66;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_cnt = 0;
	position_board board = new();

	tms_adc_if #(.SAMPLE_BITS(SBITS)) adc ();
	tms_pos_if #(.SAMPLE_BITS(SBITS)) pos ();

	touch_median_sampler #(
		.WINDOW_LEN (WIN),
		.SAMPLE_BITS(SBITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.adc   (adc),
		.pos   (pos)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver readiness: random idling, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			pos.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			pos.ready <= 1'b0;
		end else begin
			pos.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && pos.valid && pos.ready)
			board.check_result(pos.pos_x, pos.pos_y, pos.touched);
	end

	// Offers one item, idling first at random, and notes it once accepted.
	task automatic send_item(input logic pressed, input sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			adc.valid <= 1'b0;
			@(posedge clk);
		end
		adc.valid <= 1'b1;
		adc.pressed <= pressed;
		adc.sample <= s;
		@(posedge clk);
		while (!adc.ready) @(posedge clk);
		board.note_item(pressed, s);
	endtask

	// Sample content: extremes, a cluster around base, or anything.
	function automatic sample_t pick_sample(input int base);
		int mode;
		int v;
		mode = $urandom_range(0, 9);
		if (mode == 0) return '0;
		if (mode == 1) return sample_t'(MAXS);
		if (mode < 5) begin
			v = base + $urandom_range(0, 31) - 16;
			if (v < 0) v = 0;
			if (v > MAXS) v = MAXS;
			return sample_t'(v);
		end
		return sample_t'($urandom);
	endfunction

	// Mostly complete readings, some aborted ones, and stray items.
	task automatic run_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned pick;
		int unsigned len;
		int base;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			base = $urandom_range(0, MAXS);
			if (pick < 70) begin
				for (int k = 0; k < SEQ; k++) send_item(1'b1, pick_sample(base));
				sent += SEQ;
				if ($urandom_range(0, 1)) begin
					send_item(1'b0, sample_t'($urandom));
					sent++;
				end
			end else if (pick < 85) begin
				len = $urandom_range(1, SEQ - 1);
				for (int k = 0; k < len; k++) send_item(1'b1, pick_sample(base));
				send_item(1'b0, sample_t'($urandom));
				sent += len + 1;
			end else begin
				send_item(1'(($urandom_range(0, 1))), sample_t'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		adc.valid <= 1'b0;
		adc.pressed <= 1'b0;
		adc.sample <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Release straight after reset reports the cleared position.
		send_item(1'b0, '0);
		// Full reading with duplicates and extremes in the X group.
		send_item(1'b1, sample_t'(MAXS));
		send_item(1'b1, '0);
		send_item(1'b1, sample_t'(MAXS));
		send_item(1'b1, sample_t'(100));
		send_item(1'b1, sample_t'(200));
		send_item(1'b1, sample_t'(MAXS));
		send_item(1'b1, '0);
		send_item(1'b1, sample_t'(300));
		send_item(1'b1, '0);
		for (int k = 0; k < WIN; k++) send_item(1'b1, sample_t'(MAXS));
		// Abort right after the X group: the new X is kept, Y stays.
		send_item(1'b1, '0);
		for (int k = 0; k < WIN; k++) send_item(1'b1, sample_t'(MAXS - k));
		send_item(1'b0, sample_t'(MAXS));

		// Sender sparse gaps, receiver often stalled, with one long hold-off.
		hold_req <= hold_req + 1;
		run_random(ITEMS_PHASE);

		// Roles swapped.
		send_idle_pct = 66;
		recv_idle_pct = 17;
		run_random(ITEMS_PHASE);

		// No idling at all; a hold-off fills the block while the sender keeps on.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req <= hold_req + 1;
		run_random(ITEMS_PHASE);

		adc.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule : tb_top
